// ----- hw/rtl/pram24_pkg.sv -----
// ----------------------------------------------------------------------------
// Polygon RAM package
// Shared constants, access codes and item types for the 24-bit polygon RAM.
// ----------------------------------------------------------------------------
package pram24_pkg;

    localparam int unsigned RAM_WORDS_DEF = 32768;
    localparam int unsigned DATA_W        = 24;

    localparam logic [31:0] WIN_BASE = 32'h7000_0000;
    localparam logic [31:0] TOP_ONES = 32'hFF00_0000;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    typedef struct packed {
        logic        command;
        logic [31:0] address;
        logic [1:0]  access_size;
        logic [31:0] write_data;
    } access_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_data;
    } result_t;

    typedef struct packed {
        logic       command;
        logic [1:0] lane;
        logic [1:0] access_size;
    } lane_ctrl_t;

endpackage

// ----- hw/rtl/pram24_lane.sv -----
// ----------------------------------------------------------------------------
// Polygon RAM lane unit
// Selects the read lane and merges the write lane of one stored word.
// ----------------------------------------------------------------------------
module pram24_lane
(
    input  pram24_pkg::lane_ctrl_t          ctrl,
    input  logic [pram24_pkg::DATA_W-1:0]   stored,
    input  logic [31:0]                     wdata,
    output logic [pram24_pkg::DATA_W-1:0]   merged,
    output logic [31:0]                     rdata
);

    logic [31:0] word;
    logic [31:0] full;
    logic [31:0] rd;
    logic [31:0] mg;

    always_comb
    begin
        word = {{8{stored[pram24_pkg::DATA_W-1]}}, stored};
        full = pram24_pkg::TOP_ONES | {8'h00, stored};
        rd   = 32'h0;
        mg   = word;
        case (ctrl.access_size)
            pram24_pkg::SIZE_WORD:
            begin
                rd = full;
                mg = wdata;
            end
            pram24_pkg::SIZE_HALF:
            begin
                if (ctrl.lane[1])
                begin
                    rd = {16'h0, full[15:0]};
                    mg = {word[31:16], wdata[15:0]};
                end
                else
                begin
                    rd = {16'h0, full[31:16]};
                    mg = {wdata[15:0], word[15:0]};
                end
            end
            default:
            begin
                case (ctrl.lane)
                    2'd0:
                    begin
                        rd = {24'h0, full[31:24]};
                        mg = {wdata[7:0], word[23:0]};
                    end
                    2'd1:
                    begin
                        rd = {24'h0, full[23:16]};
                        mg = {word[31:24], wdata[7:0], word[15:0]};
                    end
                    2'd2:
                    begin
                        rd = {24'h0, full[15:8]};
                        mg = {word[31:16], wdata[7:0], word[7:0]};
                    end
                    default:
                    begin
                        rd = {24'h0, full[7:0]};
                        mg = {word[31:8], wdata[7:0]};
                    end
                endcase
            end
        endcase
        merged = mg[pram24_pkg::DATA_W-1:0];
        rdata  = (ctrl.command == pram24_pkg::CMD_READ) ? rd : 32'h0;
    end

endmodule

// ----- hw/rtl/polygon_ram_24bit_access.sv -----
// ----------------------------------------------------------------------------
// Polygon RAM, 24-bit access
// Big-endian polygon RAM window with 24 connected data bits per word.
// ----------------------------------------------------------------------------
// The accepted access is registered into the merge stage, then its result item into
// the output stage. Throughput: one item per cycle while the output is not stalled;
// the RAM read is registered and a write to the entry read in the same cycle is
// forwarded from the merge stage. Reset: a clearing pass writes zero to every word
// (RAM_WORDS, 32768 by default), one word a cycle; no item is accepted until it ends.
// ----------------------------------------------------------------------------
module polygon_ram_24bit_access
#(
    parameter int unsigned RAM_WORDS = pram24_pkg::RAM_WORDS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pram24_pkg::access_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pram24_pkg::result_t out_data
);

    localparam int unsigned IDX_W = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RAM_WORDS - 1);
    localparam logic [29:0] WORDS_30 = 30'(RAM_WORDS);

    logic [pram24_pkg::DATA_W-1:0] mem [RAM_WORDS];

    logic                          clear_reg;
    logic [IDX_W-1:0]              clr_idx_reg;
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic                          s1_hit_reg;
    pram24_pkg::lane_ctrl_t        s1_ctrl_reg;
    logic [31:0]                   s1_wdata_reg;
    logic [IDX_W-1:0]              s1_idx_reg;
    logic [pram24_pkg::DATA_W-1:0] rdata_reg;
    logic                          fwd_valid_reg;
    logic                          fwd_valid_next;
    logic [pram24_pkg::DATA_W-1:0] fwd_data_reg;
    logic                          out_valid_reg;
    pram24_pkg::result_t           out_data_reg;

    logic [31:0]                   offset;
    logic                          in_hit;
    logic [IDX_W-1:0]              in_idx;
    logic                          in_acc;
    logic                          out_free;
    logic                          s1_adv;
    logic                          s1_wr;
    logic [pram24_pkg::DATA_W-1:0] stored;
    logic [pram24_pkg::DATA_W-1:0] merged;
    logic [31:0]                   lane_rdata;

    always_comb
    begin
        offset   = in_data.address - pram24_pkg::WIN_BASE;
        in_hit   = (in_data.address >= pram24_pkg::WIN_BASE) && (offset[31:2] < WORDS_30);
        in_idx   = offset[IDX_W+1:2];
        out_free = !out_valid_reg || out_ready;
        s1_adv   = s1_valid_reg && out_free;
        in_ready = !clear_reg && (!s1_valid_reg || out_free);
        in_acc   = in_valid && in_ready;
        s1_wr    = s1_adv && s1_hit_reg && (s1_ctrl_reg.command == pram24_pkg::CMD_WRITE);
        stored   = fwd_valid_reg ? fwd_data_reg : rdata_reg;

        s1_valid_next = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        fwd_valid_next = in_acc ? (in_hit && s1_wr && (in_idx == s1_idx_reg))
                                : (s1_adv ? 1'b0 : fwd_valid_reg);
    end

    pram24_lane u_lane
    (
        .ctrl   (s1_ctrl_reg),
        .stored (stored),
        .wdata  (s1_wdata_reg),
        .merged (merged),
        .rdata  (lane_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (clear_reg)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (s1_wr)
        begin
            mem[s1_idx_reg] <= merged;
        end
        if (in_acc && in_hit)
        begin
            rdata_reg <= mem[in_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_hit_reg          <= in_hit;
            s1_ctrl_reg.command <= in_data.command;
            s1_ctrl_reg.lane    <= in_data.address[1:0];
            s1_ctrl_reg.access_size <= in_data.access_size;
            s1_wdata_reg        <= in_data.write_data;
            s1_idx_reg          <= in_idx;
            fwd_data_reg        <= merged;
        end
        if (s1_adv)
        begin
            out_data_reg.hit       <= s1_hit_reg;
            out_data_reg.read_data <= s1_hit_reg ? lane_rdata : 32'h0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg     <= 1'b1;
            clr_idx_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear_reg)
            begin
                if (clr_idx_reg == LAST_IDX)
                begin
                    clear_reg <= 1'b0;
                end
                else
                begin
                    clr_idx_reg <= clr_idx_reg + IDX_W'(1);
                end
            end
            s1_valid_reg  <= s1_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> !s1_valid_reg && !out_valid_reg)
        else $error("An item is in flight during the clearing pass.");

    a_fwd_owner: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> s1_valid_reg && s1_hit_reg)
        else $error("Forwarded data is held without a hitting item in the merge stage.");

    a_write_port: assert property (@(posedge clk) disable iff (!rst_n)
        s1_wr |-> !clear_reg)
        else $error("An item write collides with the clearing pass.");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_free |=> s1_valid_reg && $stable(s1_idx_reg))
        else $error("The merge stage lost its item while the output was stalled.");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.hit |-> out_data_reg.read_data == 32'h0)
        else $error("A miss item carries non-zero read data.");

endmodule

// ----- test/polygon_ram_24bit_access_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Polygon RAM, 24-bit access: testbench
// Drives read and write accesses of every size into the RAM window, around its
// edges and far outside it, and checks each result item against a typed table row
// or a local model of the 24-bit store. A short table of directed accesses comes
// first, then random traffic that mostly hits a handful of words so that reads
// follow writes to the same entry closely. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module polygon_ram_24bit_access_tb;

    localparam int unsigned RAM_WORDS  = pram24_pkg::RAM_WORDS_DEF;
    localparam logic [31:0] WIN_BASE   = pram24_pkg::WIN_BASE;
    localparam logic [31:0] TOP_ONES   = pram24_pkg::TOP_ONES;
    localparam logic        CMD_READ   = pram24_pkg::CMD_READ;
    localparam logic        CMD_WRITE  = pram24_pkg::CMD_WRITE;
    localparam logic [1:0]  SIZE_BYTE  = pram24_pkg::SIZE_BYTE;
    localparam logic [1:0]  SIZE_HALF  = pram24_pkg::SIZE_HALF;
    localparam logic [1:0]  SIZE_WORD  = pram24_pkg::SIZE_WORD;
    localparam logic [31:0] WIN_END    = WIN_BASE + 32'(4 * RAM_WORDS);
    localparam logic [31:0] LAST_WORD  = WIN_END - 32'd4;
    localparam logic [31:0] HALF_MASK  = 32'h0000_FFFF;
    localparam logic [31:0] BYTE_MASK  = 32'h0000_00FF;
    localparam logic [1:0]  SIZE_SPARE = 2'd3;

    localparam int N_RANDOM   = 1825;
    localparam int QUIET_TAIL = 200;
    localparam int HOLD_AT    = 700;
    localparam int LONG_HOLD  = 300;
    localparam int N_DIRECTED = 26;

    typedef struct packed {
        logic        command;
        logic [31:0] address;
        logic [1:0]  access_size;
        logic [31:0] write_data;
        logic        typed;
        logic        hit;
        logic [31:0] read_data;
    } directed_row_t;

    // The typed rows give their expected result directly; the others take it from the predictor.
    localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{CMD_READ,  WIN_BASE,              SIZE_WORD,  32'h0000_0000, 1'b1, 1'b1, 32'hFF00_0000},
        '{CMD_READ,  LAST_WORD,             SIZE_WORD,  32'h0000_0000, 1'b1, 1'b1, 32'hFF00_0000},
        '{CMD_READ,  WIN_BASE - 32'd1,      SIZE_BYTE,  32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{CMD_READ,  WIN_END,               SIZE_WORD,  32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{CMD_WRITE, 32'hFFFF_FFFF,         SIZE_WORD,  32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
        '{CMD_WRITE, 32'h0000_0000,         SIZE_HALF,  32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
        '{CMD_WRITE, WIN_BASE,              SIZE_WORD,  32'h1234_5678, 1'b1, 1'b1, 32'h0000_0000},
        '{CMD_READ,  WIN_BASE,              SIZE_WORD,  32'h0000_0000, 1'b1, 1'b1, 32'hFF34_5678},
        '{CMD_READ,  WIN_BASE,              SIZE_BYTE,  32'h0000_0000, 1'b1, 1'b1, 32'h0000_00FF},
        '{CMD_READ,  WIN_BASE + 32'd1,      SIZE_BYTE,  32'h0000_0000, 1'b1, 1'b1, 32'h0000_0034},
        '{CMD_READ,  WIN_BASE + 32'd2,      SIZE_BYTE,  32'h0000_0000, 1'b1, 1'b1, 32'h0000_0056},
        '{CMD_READ,  WIN_BASE + 32'd3,      SIZE_BYTE,  32'h0000_0000, 1'b1, 1'b1, 32'h0000_0078},
        '{CMD_READ,  WIN_BASE,              SIZE_HALF,  32'h0000_0000, 1'b1, 1'b1, 32'h0000_FF34},
        '{CMD_READ,  WIN_BASE + 32'd3,      SIZE_HALF,  32'h0000_0000, 1'b1, 1'b1, 32'h0000_5678},
        '{CMD_WRITE, WIN_BASE,              SIZE_BYTE,  32'h0000_00AB, 1'b1, 1'b1, 32'h0000_0000},
        '{CMD_READ,  WIN_BASE + 32'd2,      SIZE_WORD,  32'h0000_0000, 1'b1, 1'b1, 32'hFF34_5678},
        '{CMD_WRITE, WIN_BASE + 32'd2,      SIZE_HALF,  32'hFFFF_8001, 1'b0, 1'b0, 32'h0000_0000},
        '{CMD_WRITE, WIN_BASE + 32'd1,      SIZE_BYTE,  32'h0000_0080, 1'b0, 1'b0, 32'h0000_0000},
        '{CMD_READ,  WIN_BASE,              SIZE_WORD,  32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{CMD_WRITE, WIN_BASE + 32'd1,      SIZE_HALF,  32'h0000_1234, 1'b0, 1'b0, 32'h0000_0000},
        '{CMD_READ,  WIN_BASE,              SIZE_WORD,  32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{CMD_WRITE, WIN_BASE + 32'd7,      SIZE_SPARE, 32'h0000_00CD, 1'b0, 1'b0, 32'h0000_0000},
        '{CMD_READ,  WIN_BASE + 32'd7,      SIZE_SPARE, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{CMD_WRITE, WIN_END - 32'd1,       SIZE_WORD,  32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000},
        '{CMD_READ,  WIN_END - 32'd2,       SIZE_HALF,  32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{CMD_READ,  WIN_END - 32'd3,       SIZE_BYTE,  32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000}
    };

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    pram24_pkg::access_t in_data;
    logic                out_valid;
    logic                out_ready;
    pram24_pkg::result_t out_data;

    logic [23:0]         poly_words [RAM_WORDS];
    pram24_pkg::result_t pending_results [$];
    int                  mismatch_count;
    logic                quiet;
    logic                long_hold_due;
    logic                long_hold_taken;

    polygon_ram_24bit_access uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("polygon_ram_24bit_access test failed");
        $finish;
    end

    function automatic pram24_pkg::result_t predict_access(input pram24_pkg::access_t acc);
        pram24_pkg::result_t res;
        logic [31:0] offset;
        logic [31:0] word;
        logic [31:0] full;
        logic [31:0] merged;
        int unsigned idx;
        int unsigned bshift;
        int unsigned hshift;
        res = '0;
        if (acc.address >= WIN_BASE && acc.address < WIN_END)
        begin
            res.hit = 1'b1;
            offset  = acc.address - WIN_BASE;
            idx     = offset[31:2];
            bshift  = (3 - acc.address[1:0]) * 8;
            hshift  = acc.address[1] ? 0 : 16;
            word    = {{8{poly_words[idx][23]}}, poly_words[idx]};
            if (acc.command == CMD_READ)
            begin
                full = word | TOP_ONES;
                case (acc.access_size)
                    SIZE_WORD: res.read_data = full;
                    SIZE_HALF: res.read_data = (full >> hshift) & HALF_MASK;
                    default:   res.read_data = (full >> bshift) & BYTE_MASK;
                endcase
            end
            else
            begin
                case (acc.access_size)
                    SIZE_WORD: merged = acc.write_data;
                    SIZE_HALF: merged = (word & ~(HALF_MASK << hshift))
                                        | ((acc.write_data & HALF_MASK) << hshift);
                    default:   merged = (word & ~(BYTE_MASK << bshift))
                                        | ((acc.write_data & BYTE_MASK) << bshift);
                endcase
                poly_words[idx] = merged[23:0];
            end
        end
        return res;
    endfunction

    // Most accesses land on a few words so that reads closely follow writes to the same entry.
    function automatic pram24_pkg::access_t make_random_access();
        pram24_pkg::access_t acc;
        int unsigned pick;
        logic [31:0] edge_base;
        pick            = $urandom_range(0, 99);
        acc.command     = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
        acc.access_size = 2'($urandom_range(0, 3));
        acc.write_data  = $urandom();
        edge_base       = $urandom_range(0, 1) ? WIN_BASE : WIN_END;
        if (pick < 55)
            acc.address = WIN_BASE + (32'($urandom_range(0, 15)) << 2)
                          + 32'($urandom_range(0, 3));
        else if (pick < 75)
            acc.address = WIN_BASE + (32'($urandom_range(0, RAM_WORDS - 1)) << 2)
                          + 32'($urandom_range(0, 3));
        else if (pick < 85)
            acc.address = edge_base - 32'd4 + 32'($urandom_range(0, 7));
        else
            acc.address = $urandom();
        return acc;
    endfunction

    task automatic offer_access(input pram24_pkg::access_t acc, input logic typed,
                                input pram24_pkg::result_t want);
        pram24_pkg::result_t predicted;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= acc;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predicted = predict_access(acc);
        pending_results.push_back(typed ? want : predicted);
    endtask

    initial
    begin
        pram24_pkg::access_t acc;
        directed_row_t       row;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_data         = '0;
        quiet           = 1'b0;
        long_hold_due   = 1'b0;
        mismatch_count  = 0;
        for (int i = 0; i < RAM_WORDS; i++)
            poly_words[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            row             = DIRECTED_ROWS[i];
            acc.command     = row.command;
            acc.address     = row.address;
            acc.access_size = row.access_size;
            acc.write_data  = row.write_data;
            offer_access(acc, row.typed, {row.hit, row.read_data});
        end

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM - QUIET_TAIL)
                quiet = 1'b1;
            if (i == HOLD_AT)
                long_hold_due = 1'b1;
            offer_access(make_random_access(), 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("polygon_ram_24bit_access test passed");
        else
            $display("polygon_ram_24bit_access test failed");
        $finish;
    end

    // The long hold-off lets the block fill up so that it has to stall its input.
    initial
    begin
        out_ready       = 1'b0;
        long_hold_taken = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold_due && !long_hold_taken)
            begin
                long_hold_taken = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        pram24_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result item: hit=%0b read_data=%h",
                             out_data.hit, out_data.read_data);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.hit !== want.hit || out_data.read_data !== want.read_data)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected hit=%0b read_data=%h, %s hit=%0b read_data=%h",
                                 want.hit, want.read_data, "got",
                                 out_data.hit, out_data.read_data);
                end
            end
        end
    end

endmodule

// ----- filelist.f -----
hw/rtl/pram24_pkg.sv
hw/rtl/pram24_lane.sv
hw/rtl/polygon_ram_24bit_access.sv
test/polygon_ram_24bit_access_tb.sv
